// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge, disabled while reset is asserted (active low).
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== sv/mtc_pkg.sv =====
// ----------------------------------------------------------------------------
// mtc_pkg
// Types, constants and the control store of the melody note timer calculator.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // field widths
    localparam int FREQ_W  = 16;
    localparam int DIVR_W  = 8;
    localparam int TEMPO_W = 10;
    localparam int CFG_W   = 16;
    localparam int DUR_W   = 19;
    localparam int LOW_W   = 16;
    localparam int PRE_W   = 8;
    localparam int TICK_W  = LOW_W + PRE_W;   // kept bits of the tone period
    localparam int DEN_W   = 16;              // divisor width of the shared divider
    localparam int WHOLE_W = 18;              // 240000 needs 18 bits

    localparam logic [WHOLE_W-1:0] WHOLE_MS_BPM = 18'd240000;  // 60000 ms * 4 beats

    // register reset values
    localparam logic [TEMPO_W-1:0] TEMPO_RST = 10'd120;
    localparam logic [FREQ_W-1:0]  FMIN_RST  = 16'd3;
    localparam logic [FREQ_W-1:0]  FMAX_RST  = 16'd8000;

    // register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FMIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FMAX  = 2'd2;

    // sequencer
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE       = 4'd0;
    localparam step_t STEP_GO_WHOLE   = 4'd1;
    localparam step_t STEP_WT_WHOLE   = 4'd2;
    localparam step_t STEP_GO_DUR     = 4'd3;
    localparam step_t STEP_WT_DUR     = 4'd4;
    localparam step_t STEP_CHK_FREQ   = 4'd5;
    localparam step_t STEP_GO_TICK    = 4'd6;
    localparam step_t STEP_WT_TICK    = 4'd7;
    localparam step_t STEP_TICK_ZERO  = 4'd8;
    localparam step_t STEP_OUT        = 4'd9;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_DIV_BUSY,
        C_DIV_ZERO,
        C_FREQ_BAD,
        C_OUT_FULL
    } cond_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_START_WHOLE,
        A_START_DUR,
        A_START_TICK,
        A_WR_WHOLE,
        A_WR_DUR,
        A_WR_TICKS,
        A_WR_TICKS_ZERO,
        A_WR_OUT
    } act_t;

    // one control word: stall while wait_c holds, then do act, then branch
    // to br_tgt if br_c holds, else fall through
    typedef struct packed {
        cond_t wait_c;
        act_t  act;
        cond_t br_c;
        step_t br_tgt;
    } ucw_t;

    function automatic ucw_t ucode(input step_t step);
        ucw_t w;
        case (step)
            STEP_IDLE:      w = '{C_NO_ITEM,  A_ACCEPT,        C_NEVER,    STEP_IDLE};
            STEP_GO_WHOLE:  w = '{C_NEVER,    A_START_WHOLE,   C_NEVER,    STEP_IDLE};
            STEP_WT_WHOLE:  w = '{C_DIV_BUSY, A_WR_WHOLE,      C_DIV_ZERO, STEP_CHK_FREQ};
            STEP_GO_DUR:    w = '{C_NEVER,    A_START_DUR,     C_NEVER,    STEP_IDLE};
            STEP_WT_DUR:    w = '{C_DIV_BUSY, A_WR_DUR,        C_NEVER,    STEP_IDLE};
            STEP_CHK_FREQ:  w = '{C_NEVER,    A_NONE,          C_FREQ_BAD, STEP_TICK_ZERO};
            STEP_GO_TICK:   w = '{C_NEVER,    A_START_TICK,    C_NEVER,    STEP_IDLE};
            STEP_WT_TICK:   w = '{C_DIV_BUSY, A_WR_TICKS,      C_ALWAYS,   STEP_OUT};
            STEP_TICK_ZERO: w = '{C_NEVER,    A_WR_TICKS_ZERO, C_NEVER,    STEP_IDLE};
            STEP_OUT:       w = '{C_OUT_FULL, A_WR_OUT,        C_ALWAYS,   STEP_IDLE};
            default:        w = '{C_NEVER,    A_NONE,          C_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/mtc_div.sv =====
// ----------------------------------------------------------------------------
// mtc_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtc_div #(
    parameter int DIV_W = 26
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [DIV_W-1:0]            dividend,
    input  logic [mtc_pkg::DEN_W-1:0]   divisor,
    output logic                        busy,
    output logic [DIV_W-1:0]            quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                        busy_reg, busy_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [DIV_W-1:0]            num_reg, num_next;   // dividend in, quotient out
    logic [mtc_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [mtc_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [mtc_pkg::DEN_W:0]     trial;
    logic                        qbit;

    always_comb begin
        trial     = {rem_reg, num_reg[DIV_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops safely
            rem_next = qbit ? mtc_pkg::DEN_W'(trial - {1'b0, den_reg})
                            : trial[mtc_pkg::DEN_W-1:0];
            num_next = {num_reg[DIV_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

// ===== sv/melody_note_timer_calc_top.sv =====
// ----------------------------------------------------------------------------
// melody_note_timer_calc_top
// Note duration and PWM tone timer settings from one melody note.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one note item (frequency, signed length divider), valid/ready.
//   m_ channel: one result item per note: freq_ok, period and half-period
//     split into 16-bit low and 8-bit prescale parts, duration in ms.
//   cfg port: write enable, index and data; tempo, min and max frequency.
//     Write only while the block is idle.
// Timing:
//   A microcoded sequencer drives one shared serial divider (one quotient
//   bit per cycle, DIV_W = 26 at 48 MHz).
//   Up to three divisions per note: whole-note time, note duration, period.
//   A zero divider skips the duration division; an out-of-range frequency
//   skips the period division.
//   One note at a time: s_ready returns in the same cycle that m_valid rises.
// Reset:
//   Registers return to tempo 120, range 3..8000 Hz; held duration is 0.
// Stall:
//   The result sits in the output register; the next note is accepted and
//   computed meanwhile and waits at the last step until the slot frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module melody_note_timer_calc_top #(
    parameter int CLOCK_HZ = 48000000
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config
    input  logic                              cfg_we,
    input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mtc_pkg::CFG_W-1:0]         cfg_wdata,
    // note in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mtc_pkg::FREQ_W-1:0]        s_note_freq,
    input  logic signed [mtc_pkg::DIVR_W-1:0] s_note_divider,
    // result out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_freq_ok,
    output logic [mtc_pkg::LOW_W-1:0]         m_load_low,
    output logic [mtc_pkg::PRE_W-1:0]         m_load_prescale,
    output logic [mtc_pkg::LOW_W-1:0]         m_match_low,
    output logic [mtc_pkg::PRE_W-1:0]         m_match_prescale,
    output logic [mtc_pkg::DUR_W-1:0]         m_duration_ms
);

    localparam int CLK_W = $clog2(CLOCK_HZ + 1);
    localparam int DIV_W = (CLK_W > mtc_pkg::WHOLE_W) ? CLK_W : mtc_pkg::WHOLE_W;
    localparam int TK1_W = mtc_pkg::TICK_W + 1;   // period bits plus one for the half

    // ---------------- configuration registers ----------------
    logic [mtc_pkg::TEMPO_W-1:0] tempo_reg;
    logic [mtc_pkg::FREQ_W-1:0]  fmin_reg;
    logic [mtc_pkg::FREQ_W-1:0]  fmax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tempo_reg <= mtc_pkg::TEMPO_RST;
            fmin_reg  <= mtc_pkg::FMIN_RST;
            fmax_reg  <= mtc_pkg::FMAX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                mtc_pkg::CFG_TEMPO: tempo_reg <= cfg_wdata[mtc_pkg::TEMPO_W-1:0];
                mtc_pkg::CFG_FMIN:  fmin_reg  <= cfg_wdata;
                mtc_pkg::CFG_FMAX:  fmax_reg  <= cfg_wdata;
                default: ;  // index beyond the register list: dropped
            endcase
        end
    end

    // ---------------- sequencer and datapath ----------------
    mtc_pkg::step_t              pc_reg, pc_next;
    mtc_pkg::ucw_t               cw;
    logic                        waiting, fire, branch;

    logic [mtc_pkg::FREQ_W-1:0]  freq_reg;
    logic [mtc_pkg::DIVR_W-1:0]  divr_reg;
    logic [DIV_W-1:0]            whole_reg;
    logic [mtc_pkg::DUR_W-1:0]   dur_reg;      // doubles as the held duration
    logic [TK1_W-1:0]            ticks_reg;
    logic                        ok_reg;

    logic                        m_valid_reg;
    logic                        m_freq_ok_reg;
    logic [mtc_pkg::LOW_W-1:0]   m_load_low_reg, m_match_low_reg;
    logic [mtc_pkg::PRE_W-1:0]   m_load_pre_reg, m_match_pre_reg;
    logic [mtc_pkg::DUR_W-1:0]   m_dur_reg;

    // divider hookup
    logic                        div_start, div_busy;
    logic [DIV_W-1:0]            div_num, div_quot;
    logic [mtc_pkg::DEN_W-1:0]   div_den;

    logic [mtc_pkg::TEMPO_W-1:0] tempo_eff;
    logic [mtc_pkg::DIVR_W-1:0]  mag;
    logic                        freq_bad, out_full;
    logic [mtc_pkg::DUR_W-1:0]   q_dur;
    logic [TK1_W-1:0]            q_tick;

    assign tempo_eff = (tempo_reg == '0) ? mtc_pkg::TEMPO_W'(1) : tempo_reg;
    // two's complement negate; -128 comes out as 128 unsigned
    assign mag       = divr_reg[mtc_pkg::DIVR_W-1] ? (~divr_reg + 1'b1) : divr_reg;
    assign freq_bad  = (freq_reg == '0) || (freq_reg < fmin_reg) || (freq_reg > fmax_reg);
    assign out_full  = m_valid_reg && !m_ready;
    assign q_dur     = mtc_pkg::DUR_W'(div_quot);
    assign q_tick    = TK1_W'(div_quot);

    function automatic logic cond_eval(input mtc_pkg::cond_t c, input logic no_item,
                                       input logic busy, input logic dzero,
                                       input logic fbad, input logic ofull);
        logic r;
        case (c)
            mtc_pkg::C_NEVER:    r = 1'b0;
            mtc_pkg::C_ALWAYS:   r = 1'b1;
            mtc_pkg::C_NO_ITEM:  r = no_item;
            mtc_pkg::C_DIV_BUSY: r = busy;
            mtc_pkg::C_DIV_ZERO: r = dzero;
            mtc_pkg::C_FREQ_BAD: r = fbad;
            mtc_pkg::C_OUT_FULL: r = ofull;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb begin
        cw      = mtc_pkg::ucode(pc_reg);
        waiting = cond_eval(cw.wait_c, !s_valid, div_busy, divr_reg == '0,
                            freq_bad, out_full);
        fire    = !waiting;
        branch  = cond_eval(cw.br_c, !s_valid, div_busy, divr_reg == '0,
                            freq_bad, out_full);
        if (!fire) begin
            pc_next = pc_reg;
        end else if (branch) begin
            pc_next = cw.br_tgt;
        end else begin
            pc_next = pc_reg + 1'b1;
        end

        div_start = 1'b0;
        div_num   = DIV_W'(CLOCK_HZ);
        div_den   = freq_reg;
        case (cw.act)
            mtc_pkg::A_START_WHOLE: begin
                div_start = 1'b1;
                div_num   = DIV_W'(mtc_pkg::WHOLE_MS_BPM);
                div_den   = mtc_pkg::DEN_W'(tempo_eff);
            end
            mtc_pkg::A_START_DUR: begin
                div_start = 1'b1;
                div_num   = whole_reg;
                div_den   = mtc_pkg::DEN_W'(mag);
            end
            mtc_pkg::A_START_TICK: begin
                div_start = 1'b1;
                div_num   = DIV_W'(CLOCK_HZ);
                div_den   = freq_reg;
            end
            default: ;
        endcase
    end

    assign s_ready = (pc_reg == mtc_pkg::STEP_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= mtc_pkg::STEP_IDLE;
            dur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire) begin
                case (cw.act)
                    mtc_pkg::A_WR_DUR: begin
                        // dotted: q + q/2
                        dur_reg <= divr_reg[mtc_pkg::DIVR_W-1] ? (q_dur + (q_dur >> 1))
                                                               : q_dur;
                    end
                    mtc_pkg::A_WR_OUT: m_valid_reg <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (fire) begin
            case (cw.act)
                mtc_pkg::A_ACCEPT: begin
                    freq_reg <= s_note_freq;
                    divr_reg <= s_note_divider;
                end
                mtc_pkg::A_WR_WHOLE: whole_reg <= div_quot;
                mtc_pkg::A_WR_TICKS: begin
                    ticks_reg <= q_tick;
                    ok_reg    <= 1'b1;
                end
                mtc_pkg::A_WR_TICKS_ZERO: begin
                    ticks_reg <= '0;
                    ok_reg    <= 1'b0;
                end
                mtc_pkg::A_WR_OUT: begin
                    m_freq_ok_reg   <= ok_reg;
                    m_load_low_reg  <= ticks_reg[mtc_pkg::LOW_W-1:0];
                    m_load_pre_reg  <= ticks_reg[mtc_pkg::TICK_W-1:mtc_pkg::LOW_W];
                    m_match_low_reg <= ticks_reg[mtc_pkg::LOW_W:1];
                    m_match_pre_reg <= ticks_reg[mtc_pkg::TICK_W:mtc_pkg::LOW_W+1];
                    m_dur_reg       <= dur_reg;
                end
                default: ;
            endcase
        end
    end

    mtc_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign m_valid          = m_valid_reg;
    assign m_freq_ok        = m_freq_ok_reg;
    assign m_load_low       = m_load_low_reg;
    assign m_load_prescale  = m_load_pre_reg;
    assign m_match_low      = m_match_low_reg;
    assign m_match_prescale = m_match_pre_reg;
    assign m_duration_ms    = m_dur_reg;

    // ---------------- assertions ----------------
    // divider is only busy while the program waits on it
    `ASSERT_RST(a_busy_in_wait, aclk, aresetn,
        div_busy |-> (pc_reg == mtc_pkg::STEP_WT_WHOLE || pc_reg == mtc_pkg::STEP_WT_DUR
                      || pc_reg == mtc_pkg::STEP_WT_TICK))
    // no restart of a running division
    `ASSERT_RST(a_no_restart, aclk, aresetn, div_start |-> !div_busy)
    // held duration only moves through the duration write
    `ASSERT_RST(a_dur_write, aclk, aresetn,
        (fire && cw.act != mtc_pkg::A_WR_DUR) |=> $stable(dur_reg))
    // a rejected frequency leaves all timer fields zero
    `ASSERT_RST(a_bad_zero, aclk, aresetn,
        (fire && cw.act == mtc_pkg::A_WR_OUT) |=> (m_freq_ok || (m_load_low == '0
            && m_load_prescale == '0 && m_match_low == '0 && m_match_prescale == '0)))

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for melody_note_timer_calc_top: random and directed
// notes under several tempo and frequency-range settings, checked item by item
// against an in-bench model of the duration and tone timer arithmetic.
// ----------------------------------------------------------------------------
module tb;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int          CLK_HZ       = 48000000;  // matches the DUT default
    localparam int          WDOG_LIMIT   = 4000;      // cycles with no handshake or register write
    localparam int          HOLD_CYCLES  = 400;       // long receiver hold-off
    localparam int          TAIL_CYCLES  = 120;       // about one note latency and then some
    localparam int          RAND_PHASES  = 8;
    localparam int          RAND_ITEMS   = 100;       // per random phase
    // the index port has one code past the last register; writes to it are dropped
    localparam logic [mtc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [mtc_pkg::FREQ_W-1:0]        freq;
        logic signed [mtc_pkg::DIVR_W-1:0] divider;
    } note_t;

    typedef struct packed {
        logic                       freq_ok;
        logic [mtc_pkg::LOW_W-1:0]  load_low;
        logic [mtc_pkg::PRE_W-1:0]  load_prescale;
        logic [mtc_pkg::LOW_W-1:0]  match_low;
        logic [mtc_pkg::PRE_W-1:0]  match_prescale;
        logic [mtc_pkg::DUR_W-1:0]  duration_ms;
    } tone_t;

    // ------------------------------------------------------------------------
    // DUT signals, the bench-driven inputs all known from time zero
    // ------------------------------------------------------------------------
    logic                                 aclk           = 1'b0;
    logic                                 aresetn        = 1'b0;
    logic                                 cfg_we         = 1'b0;
    logic [mtc_pkg::CFG_IDX_W-1:0]        cfg_index      = '0;
    logic [mtc_pkg::CFG_W-1:0]            cfg_wdata      = '0;
    logic                                 s_valid        = 1'b0;
    logic                                 s_ready;
    logic [mtc_pkg::FREQ_W-1:0]           s_note_freq    = '0;
    logic signed [mtc_pkg::DIVR_W-1:0]    s_note_divider = '0;
    logic                                 m_valid;
    logic                                 m_ready        = 1'b0;
    logic                                 m_freq_ok;
    logic [mtc_pkg::LOW_W-1:0]            m_load_low;
    logic [mtc_pkg::PRE_W-1:0]            m_load_prescale;
    logic [mtc_pkg::LOW_W-1:0]            m_match_low;
    logic [mtc_pkg::PRE_W-1:0]            m_match_prescale;
    logic [mtc_pkg::DUR_W-1:0]            m_duration_ms;

    melody_note_timer_calc_top #(
        .CLOCK_HZ(CLK_HZ)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_note_freq      (s_note_freq),
        .s_note_divider   (s_note_divider),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_freq_ok        (m_freq_ok),
        .m_load_low       (m_load_low),
        .m_load_prescale  (m_load_prescale),
        .m_match_low      (m_match_low),
        .m_match_prescale (m_match_prescale),
        .m_duration_ms    (m_duration_ms)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    note_t  note_q[$];      // notes waiting to be offered
    tone_t  tone_q[$];      // predicted results, oldest first
    int     err_cnt    = 0;
    int     note_cnt   = 0;
    int     result_cnt = 0;
    int     in_range_cnt = 0;
    int     cfg_cnt    = 0;
    int     phase_cnt  = 0;
    logic   note_taken = 1'b0;  // item accepted at the last rising edge
    bit     calm       = 1'b0;  // phase with no idling on either side
    bit     hold_req   = 1'b0;  // asks the receiver for one long hold-off

    // model copies of the registers and the held duration
    logic [mtc_pkg::TEMPO_W-1:0] tempo_q  = mtc_pkg::TEMPO_RST;
    logic [mtc_pkg::FREQ_W-1:0]  fmin_q   = mtc_pkg::FMIN_RST;
    logic [mtc_pkg::FREQ_W-1:0]  fmax_q   = mtc_pkg::FMAX_RST;
    logic [mtc_pkg::DUR_W-1:0]   held_dur = '0;

    // ------------------------------------------------------------------------
    // Clock: 8 ns period
    // ------------------------------------------------------------------------
    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Gap lengths: mostly zero or short, a few long
    // ------------------------------------------------------------------------
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // ------------------------------------------------------------------------
    // Note arithmetic: duration from tempo and divider, tone period split
    // into low/prescale parts. Out-of-range tones zero the timer fields.
    // ------------------------------------------------------------------------
    function automatic tone_t calc_tone(input logic [mtc_pkg::FREQ_W-1:0] freq,
                                        input logic [mtc_pkg::DIVR_W-1:0] div,
                                        input logic [mtc_pkg::TEMPO_W-1:0] tempo,
                                        input logic [mtc_pkg::FREQ_W-1:0] fmin,
                                        input logic [mtc_pkg::FREQ_W-1:0] fmax,
                                        input logic [mtc_pkg::DUR_W-1:0] held);
        tone_t       t;
        int unsigned bpm, whole, mag, q, dur, ticks, half;
        t   = '0;
        bpm = (tempo == '0) ? 32'd1 : 32'(tempo);     // zero tempo counts as 1 bpm
        whole = 32'(mtc_pkg::WHOLE_MS_BPM) / bpm;
        if (div == '0) begin
            dur = 32'(held);
        end else if (!div[mtc_pkg::DIVR_W-1]) begin
            dur = whole / 32'(div);
        end else begin
            // dotted: 1.5x, from the magnitude; -128 gives 128
            mag = (32'h100 - 32'(div)) & 32'hFF;
            q   = whole / mag;
            dur = q + q / 32'd2;
        end
        t.duration_ms = mtc_pkg::DUR_W'(dur);   // kept to the field width
        // a rest never passes the range check
        if (freq != '0 && freq >= fmin && freq <= fmax) begin
            ticks            = 32'(CLK_HZ) / 32'(freq);
            half             = ticks / 32'd2;
            t.freq_ok        = 1'b1;
            t.load_low       = ticks[15:0];
            t.load_prescale  = ticks[23:16];
            t.match_low      = half[15:0];
            t.match_prescale = half[23:16];
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH @%0t %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic cmp_field(input string name, input int got, input int want);
        if (got != want) report_mismatch(name, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Monitor: checks results, tracks register writes, predicts per note.
    // Everything sampled at the rising edge; the bench drives on falling.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        tone_t want;
        if (aresetn) begin
            note_taken <= s_valid && s_ready;

            if (m_valid && m_ready) begin
                result_cnt++;
                if (tone_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(m_duration_ms), 0);
                end else begin
                    want = tone_q.pop_front();
                    cmp_field("freq_ok",        32'(m_freq_ok),
                              32'(want.freq_ok));
                    cmp_field("load_low",       32'(m_load_low),
                              32'(want.load_low));
                    cmp_field("load_prescale",  32'(m_load_prescale),
                              32'(want.load_prescale));
                    cmp_field("match_low",      32'(m_match_low),
                              32'(want.match_low));
                    cmp_field("match_prescale", 32'(m_match_prescale),
                              32'(want.match_prescale));
                    cmp_field("duration_ms",    32'(m_duration_ms),
                              32'(want.duration_ms));
                    if (want.freq_ok) in_range_cnt++;
                end
            end

            if (cfg_we) begin
                cfg_cnt++;
                case (cfg_index)
                    mtc_pkg::CFG_TEMPO: tempo_q = cfg_wdata[mtc_pkg::TEMPO_W-1:0];
                    mtc_pkg::CFG_FMIN:  fmin_q  = cfg_wdata;
                    mtc_pkg::CFG_FMAX:  fmax_q  = cfg_wdata;
                    default: ;   // spare index: dropped
                endcase
            end

            if (s_valid && s_ready) begin
                note_cnt++;
                want     = calc_tone(s_note_freq, s_note_divider, tempo_q,
                                     fmin_q, fmax_q, held_dur);
                held_dur = want.duration_ms;   // every note updates the held duration
                tone_q.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Note driver: pops the pending queue, holds each item until taken,
    // then idles for a random gap. valid is written at most once per falling edge.
    // ------------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge aclk) begin
        note_t n;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !note_taken) begin
            // still waiting for the handshake
        end else if (send_gap > 0) begin
            send_gap--;
            s_valid <= 1'b0;
        end else if (note_q.size() > 0) begin
            n = note_q.pop_front();
            s_valid        <= 1'b1;
            s_note_freq    <= n.freq;
            s_note_divider <= n.divider;
            send_gap = calm ? 0 : draw_gap();   // applies once this item is taken
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off on request,
    // counted here so the sender keeps pushing and the DUT backs up.
    // ------------------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_seen  = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = draw_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake or write ends the run
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WDOG_LIMIT) begin
                    $display("watchdog: %0d cycles without progress, %0d results pending",
                             idle_cycles, tone_q.size());
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [mtc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mtc_pkg::CFG_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic push_note(input logic [mtc_pkg::FREQ_W-1:0] freq,
                             input logic [mtc_pkg::DIVR_W-1:0] div);
        note_t n;
        n.freq    = freq;
        n.divider = div;
        note_q.push_back(n);
    endtask

    // wait until every note is taken and every result is back; the DUT is
    // then idle since each note yields exactly one result
    task automatic drain();
        while (note_q.size() != 0 || s_valid || tone_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
        phase_cnt++;
    endtask

    // mostly well-formed notes inside the current range, some raw 16-bit noise
    task automatic random_notes(input int count, input logic [mtc_pkg::FREQ_W-1:0] fmin,
                                input logic [mtc_pkg::FREQ_W-1:0] fmax);
        logic [mtc_pkg::FREQ_W-1:0] f;
        logic [mtc_pkg::DIVR_W-1:0] d;
        for (int i = 0; i < count; i++) begin
            if (fmin <= fmax && $urandom_range(0, 9) < 7)
                f = mtc_pkg::FREQ_W'($urandom_range(32'(fmin), 32'(fmax)));
            else
                f = mtc_pkg::FREQ_W'($urandom());
            if ($urandom_range(0, 99) < 15)
                d = '0;               // repeat last duration
            else
                d = mtc_pkg::DIVR_W'($urandom());
            push_note(f, d);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [mtc_pkg::CFG_W-1:0] tempo_w, fmin_w, fmax_w;
        int                        pick;

        // synchronous reset, released on a falling edge
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // -- directed: reset settings (120 bpm, 3..8000 Hz) --
        push_note(16'd0,     8'sd4);      // rest
        push_note(16'd3,     8'sd1);      // lowest accepted, whole note
        push_note(16'd2,     8'sd2);      // just below range
        push_note(16'd8000,  -8'sd1);     // highest accepted, dotted whole
        push_note(16'd8001,  8'h80);      // just above range, most negative divider
        push_note(16'd440,   8'sd0);      // keeps previous duration
        push_note(16'd440,   8'sd127);    // largest plain divider
        push_note(16'd1000,  -8'sd2);
        push_note(16'hFFFF,  8'sd8);
        push_note(16'd1,     8'sd0);
        drain();

        // -- directed: zero tempo, widest range, rest with minimum of zero --
        write_reg(mtc_pkg::CFG_TEMPO, 16'd0);
        write_reg(mtc_pkg::CFG_FMIN,  16'd0);
        write_reg(mtc_pkg::CFG_FMAX,  16'hFFFF);
        push_note(16'd0,     8'sd1);      // still a rest
        push_note(16'd1,     -8'sd1);     // longest duration, period wraps past 24 bits
        push_note(16'd2,     8'sd0);
        push_note(16'd733,   8'sd3);      // period just under 2^16
        push_note(16'hFFFF,  8'h80);
        drain();

        // -- directed: minimum above maximum accepts nothing --
        write_reg(mtc_pkg::CFG_FMIN,  16'd5000);
        write_reg(mtc_pkg::CFG_FMAX,  16'd100);
        push_note(16'd100,   8'sd4);
        push_note(16'd5000,  -8'sd3);
        push_note(16'd1000,  8'sd0);
        drain();

        // -- directed: tempo data wider than the register, spare index ignored --
        write_reg(mtc_pkg::CFG_TEMPO, 16'hFFE8);   // low 10 bits give 1000 bpm
        write_reg(CFG_SPARE, 16'h1234);
        write_reg(mtc_pkg::CFG_FMIN,  16'd1);
        write_reg(mtc_pkg::CFG_FMAX,  16'd20000);
        push_note(16'd1,     8'sd1);
        push_note(16'd20000, -8'sd1);
        push_note(16'd20001, 8'sd127);
        push_note(16'd261,   8'sd0);
        drain();

        // -- random phases, each with its own register setting --
        for (int p = 0; p < RAND_PHASES; p++) begin
            pick = $urandom_range(0, 5);
            case (pick)
                0:       tempo_w = 16'd0;
                1:       tempo_w = 16'd1;
                2:       tempo_w = 16'hFFFF;      // masks to 1023
                default: tempo_w = mtc_pkg::CFG_W'($urandom());
            endcase
            pick = $urandom_range(0, 5);
            case (pick)
                0:       fmin_w = 16'd0;
                1:       fmin_w = 16'd1;
                2:       fmin_w = mtc_pkg::CFG_W'($urandom());
                default: fmin_w = mtc_pkg::CFG_W'($urandom_range(1, 200));
            endcase
            pick = $urandom_range(0, 5);
            case (pick)
                0:       fmax_w = 16'hFFFF;
                1:       fmax_w = mtc_pkg::CFG_W'($urandom());
                default: fmax_w = mtc_pkg::CFG_W'($urandom_range(1000, 30000));
            endcase
            write_reg(mtc_pkg::CFG_TEMPO, tempo_w);
            write_reg(mtc_pkg::CFG_FMIN,  fmin_w);
            write_reg(mtc_pkg::CFG_FMAX,  fmax_w);
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, mtc_pkg::CFG_W'($urandom()));

            calm = (p == 1);               // one phase runs flat out
            if (p == 3) hold_req = 1'b1;   // one phase backs up the output
            random_notes(RAND_ITEMS, fmin_w, fmax_w);
            drain();
            calm = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (tone_q.size() != 0) report_mismatch("results never delivered", tone_q.size(), 0);

        $display("covered %0d notes in %0d phases with %0d register writes",
                 note_cnt, phase_cnt, cfg_cnt);
        $display("checked %0d results, %0d with tone in range, %0d mismatches",
                 result_cnt, in_range_cnt, err_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
